>>> hdl/mpks_pkg.sv
// Shared types, register map and timing constants for the modem power key sequencer.
package mpks_pkg;

  localparam int TIME_BITS = 32;
  localparam int NOW_BITS  = 32;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_t;

  typedef enum logic [6:0] {
    ST_OFF       = 7'b0000001,
    ST_STABILIZE = 7'b0000010,
    ST_KEY_PULSE = 7'b0000100,
    ST_BOOT_WAIT = 7'b0001000,
    ST_READY     = 7'b0010000,
    ST_OFF_PULSE = 7'b0100000,
    ST_OFF_WAIT  = 7'b1000000
  } seq_state_t;

  localparam logic [2:0] CODE_OFF       = 3'd0;
  localparam logic [2:0] CODE_STABILIZE = 3'd1;
  localparam logic [2:0] CODE_KEY_PULSE = 3'd2;
  localparam logic [2:0] CODE_BOOT_WAIT = 3'd3;
  localparam logic [2:0] CODE_READY     = 3'd4;
  localparam logic [2:0] CODE_OFF_PULSE = 3'd5;
  localparam logic [2:0] CODE_OFF_WAIT  = 3'd6;

  localparam logic [1:0] KIND_CHECK = 2'd0;
  localparam logic [1:0] KIND_ON    = 2'd1;
  localparam logic [1:0] KIND_OFF   = 2'd2;

  localparam logic [IDX_BITS-1:0] REG_STABILIZE   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_KEY_PULSE   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_BOOT_SETTLE = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_OFF_PULSE   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_OFF_SETTLE  = 3'd4;

  localparam cfg_t STABILIZE_RST   = 16'd200;
  localparam cfg_t KEY_PULSE_RST   = 16'd1200;
  localparam cfg_t BOOT_SETTLE_RST = 16'd3000;
  localparam cfg_t OFF_PULSE_RST   = 16'd1000;
  localparam cfg_t OFF_SETTLE_RST  = 16'd2000;

  function automatic logic [2:0] state_code(input seq_state_t st);
    logic [2:0] code;
    case (st)
      ST_OFF:       code = CODE_OFF;
      ST_STABILIZE: code = CODE_STABILIZE;
      ST_KEY_PULSE: code = CODE_KEY_PULSE;
      ST_BOOT_WAIT: code = CODE_BOOT_WAIT;
      ST_READY:     code = CODE_READY;
      ST_OFF_PULSE: code = CODE_OFF_PULSE;
      ST_OFF_WAIT:  code = CODE_OFF_WAIT;
      default:      code = CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/modem_power_key_sequencer_top.sv
// Modem power rail and power key sequencer: input register, state update, result register.
// A word held in the input register has its result registered into m_tdata once the result register is free.
// Throughput: one word per cycle unless m_tready stalls; each step reads state updated by the word before it.
// s_tready stays high while the input register is empty or can move on to the result register.
// Reset (rst, synchronous): state off, rail and key low, phase start zero, timeouts to defaults.
// Reset empties both pipeline registers.
module modem_power_key_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // now_ms[31:0]
  input  logic [2:0]  s_tuser,   // kind[1:0], graceful[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // power_state[2:0], rail_enable[3], key_drive[4], ready_res[5], zero[7:6]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mpks_pkg::cfg_t stabilize_ms;
  mpks_pkg::cfg_t key_pulse_ms;
  mpks_pkg::cfg_t boot_settle_ms;
  mpks_pkg::cfg_t off_pulse_ms;
  mpks_pkg::cfg_t off_settle_ms;

  mpks_pkg::seq_state_t seq_state, seq_state_next;
  mpks_pkg::time_t      phase_start, phase_start_next;
  logic                 rail_level, rail_level_next;
  logic                 key_level, key_level_next;

  logic                          in_valid;
  logic [mpks_pkg::NOW_BITS-1:0] in_now;
  logic [1:0]                    in_kind;
  logic                          in_graceful;

  logic       out_valid;
  logic [7:0] out_data;

  logic            out_free;
  logic            advance;
  mpks_pkg::time_t now_t;
  mpks_pkg::time_t elapsed;
  mpks_pkg::cfg_t  timeout;
  logic            expired;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stabilize_ms   <= mpks_pkg::STABILIZE_RST;
      key_pulse_ms   <= mpks_pkg::KEY_PULSE_RST;
      boot_settle_ms <= mpks_pkg::BOOT_SETTLE_RST;
      off_pulse_ms   <= mpks_pkg::OFF_PULSE_RST;
      off_settle_ms  <= mpks_pkg::OFF_SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mpks_pkg::REG_STABILIZE:   stabilize_ms   <= cfg_data;
        mpks_pkg::REG_KEY_PULSE:   key_pulse_ms   <= cfg_data;
        mpks_pkg::REG_BOOT_SETTLE: boot_settle_ms <= cfg_data;
        mpks_pkg::REG_OFF_PULSE:   off_pulse_ms   <= cfg_data;
        mpks_pkg::REG_OFF_SETTLE:  off_settle_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now      <= s_tdata;
      in_kind     <= s_tuser[1:0];
      in_graceful <= s_tuser[2];
    end
  end

  assign now_t   = mpks_pkg::TIME_BITS'(in_now);
  assign elapsed = now_t - phase_start;

  always_comb begin
    case (seq_state)
      mpks_pkg::ST_STABILIZE: timeout = stabilize_ms;
      mpks_pkg::ST_KEY_PULSE: timeout = key_pulse_ms;
      mpks_pkg::ST_BOOT_WAIT: timeout = boot_settle_ms;
      mpks_pkg::ST_OFF_PULSE: timeout = off_pulse_ms;
      mpks_pkg::ST_OFF_WAIT:  timeout = off_settle_ms;
      default:                timeout = '0;
    endcase
  end

  assign expired = elapsed >= mpks_pkg::TIME_BITS'(timeout);

  always_comb begin
    seq_state_next   = seq_state;
    phase_start_next = phase_start;
    rail_level_next  = rail_level;
    key_level_next   = key_level;
    case (in_kind)
      mpks_pkg::KIND_CHECK: begin
        case (seq_state)
          mpks_pkg::ST_OFF, mpks_pkg::ST_READY: ;
          mpks_pkg::ST_STABILIZE: begin
            if (expired) begin
              key_level_next   = 1'b1;
              seq_state_next   = mpks_pkg::ST_KEY_PULSE;
              phase_start_next = now_t;
            end
          end
          mpks_pkg::ST_KEY_PULSE: begin
            if (expired) begin
              key_level_next   = 1'b0;
              seq_state_next   = mpks_pkg::ST_BOOT_WAIT;
              phase_start_next = now_t;
            end
          end
          mpks_pkg::ST_BOOT_WAIT: begin
            if (expired) begin
              seq_state_next = mpks_pkg::ST_READY;
            end
          end
          mpks_pkg::ST_OFF_PULSE: begin
            if (expired) begin
              key_level_next   = 1'b0;
              seq_state_next   = mpks_pkg::ST_OFF_WAIT;
              phase_start_next = now_t;
            end
          end
          mpks_pkg::ST_OFF_WAIT: begin
            if (expired) begin
              rail_level_next = 1'b0;
              seq_state_next  = mpks_pkg::ST_OFF;
            end
          end
          default: seq_state_next = mpks_pkg::ST_OFF;
        endcase
      end
      mpks_pkg::KIND_ON: begin
        if (seq_state != mpks_pkg::ST_READY && seq_state != mpks_pkg::ST_BOOT_WAIT) begin
          key_level_next   = 1'b0;
          rail_level_next  = 1'b1;
          seq_state_next   = mpks_pkg::ST_STABILIZE;
          phase_start_next = now_t;
        end
      end
      mpks_pkg::KIND_OFF: begin
        if (seq_state != mpks_pkg::ST_OFF) begin
          if (in_graceful && seq_state == mpks_pkg::ST_READY) begin
            key_level_next   = 1'b1;
            seq_state_next   = mpks_pkg::ST_OFF_PULSE;
            phase_start_next = now_t;
          end else begin
            key_level_next  = 1'b0;
            rail_level_next = 1'b0;
            seq_state_next  = mpks_pkg::ST_OFF;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state   <= mpks_pkg::ST_OFF;
      phase_start <= '0;
      rail_level  <= 1'b0;
      key_level   <= 1'b0;
    end else if (advance) begin
      seq_state   <= seq_state_next;
      phase_start <= phase_start_next;
      rail_level  <= rail_level_next;
      key_level   <= key_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {2'b00, seq_state_next == mpks_pkg::ST_READY, key_level_next,
                   rail_level_next, mpks_pkg::state_code(seq_state_next)};
    end
  end

  a_off_pins_low: assert property (@(posedge clk) disable iff (rst)
    seq_state == mpks_pkg::ST_OFF |-> !rail_level && !key_level)
    else $error("pins not released while off");

  a_stabilize_pins: assert property (@(posedge clk) disable iff (rst)
    seq_state == mpks_pkg::ST_STABILIZE |-> rail_level && !key_level)
    else $error("wrong pin levels while stabilising");

  a_key_needs_rail: assert property (@(posedge clk) disable iff (rst)
    key_level |-> rail_level)
    else $error("key asserted with rail off");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(seq_state) && $stable(phase_start))
    else $error("state moved without a word");

endmodule
